// ===== rtl/bbjfe_pkg.sv =====
// shared types, constants and the color cube lookup of the byte-byte-jump frame engine
package bbjfe_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_PIXEL = 2'd3
   } action_type;

   localparam int ADDRESS_W    = 25;
   localparam int PTR_W        = 24;
   localparam int STEPS_W      = 17;
   localparam int PIXEL_W      = 16;
   localparam int MAX_STEPS    = 65536;
   localparam int CUBE_STEP    = 51;
   localparam int CUBE_SIZE    = 216;
   localparam int CUBE_PLANE   = 36;
   localparam int CUBE_ROW     = 6;
   localparam int START_PC_ADR = 2;
   localparam int PAGE_ADR     = 5;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // constant 216-entry cube, indexes at or above the cube size stay black
   function automatic rgb_type cube_rgb(input logic [7:0] idx);
      rgb_type res;
      res = '0;
      for (int r = 0; r < CUBE_ROW; r++) begin
         for (int g = 0; g < CUBE_ROW; g++) begin
            for (int b = 0; b < CUBE_ROW; b++) begin
               if (idx == 8'(r * CUBE_PLANE + g * CUBE_ROW + b)) begin
                  res.red   = 8'(r * CUBE_STEP);
                  res.green = 8'(g * CUBE_STEP);
                  res.blue  = 8'(b * CUBE_STEP);
               end
            end
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/bbjfe_req_if.sv =====
// request channel of the byte-byte-jump frame engine
interface bbjfe_req_if import bbjfe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   action_type           action;
   logic [ADDRESS_W-1:0] address;
   logic [7:0]           write_data;
   logic [PIXEL_W-1:0]   pixel_index;

   modport source (output valid, action, address, write_data, pixel_index, input ready);
   modport sink   (input valid, action, address, write_data, pixel_index, output ready);
endinterface

// ===== rtl/bbjfe_rsp_if.sv =====
// response channel of the byte-byte-jump frame engine
interface bbjfe_rsp_if import bbjfe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [7:0]       read_data;
   logic [7:0]       red;
   logic [7:0]       green;
   logic [7:0]       blue;
   logic [PTR_W-1:0] final_pc;

   modport source (output valid, read_data, red, green, blue, final_pc, input ready);
   modport sink   (input valid, read_data, red, green, blue, final_pc, output ready);
endinterface

// ===== rtl/byte_byte_jump_frame_engine_unit.sv =====
// top level of the byte-byte-jump frame engine: byte memory, sequencer and response register
//
// usage
//   req_chan carries one command per beat: write byte, read byte, run frame or read pixel.
//   rsp_chan returns exactly one beat per command, in order, with final_pc always set to
//   the program counter left by the last run frame.
//   csr_we / csr_wdata set the instruction count per frame (reset 65536, values above
//   65536 act as 65536); write it only while no command is in flight.
// command sequencing (all set by the single port of the byte memory)
//   write byte : accepted every cycle while rsp_chan takes each beat, response registered at the accepting edge
//   read byte  : data registered into the response in S_RDATA; the next command waits for S_IDLE
//   read pixel : page byte at address 5, then the pixel byte
//   run frame  : start pc from bytes 2 to 4, then n instructions, n the instruction count; each instruction is nine
//                pointer byte reads, one source read and one write
// reset clears the program counter, the step counter and the response valid flag; memory
// contents are undefined until written. while a response beat is held, req_chan.ready
// stays low, so a stalled receiver blocks the next command until that beat is taken.
module byte_byte_jump_frame_engine_unit import bbjfe_pkg::*; #(
   parameter int ADDR_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   bbjfe_req_if.sink            req_chan,
   bbjfe_rsp_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic [STEPS_W-1:0]   csr_wdata
);

   localparam int IDX_BITS = ADDR_BITS + 1;
   localparam int MEM_SIZE = (1 << ADDR_BITS) + 8;

   typedef enum logic [4:0] {
      S_IDLE, S_RDATA, S_PIX5, S_PIXD,
      S_LD0, S_LD1, S_LD2, S_LD3,
      S_A1, S_A2, S_AP, S_B0, S_B1, S_B2, S_WR, S_C0, S_C1, S_C2, S_JMP
   } state_type;

   state_type            state_ff;
   logic [7:0]           memory_ff [MEM_SIZE];
   logic [7:0]           rdata_ff;
   logic [IDX_BITS-1:0]  mem_addr;
   logic                 mem_we;
   logic [7:0]           mem_wdata;

   logic [ADDR_BITS-1:0] pc_ff;
   logic [STEPS_W-1:0]   steps_ff;
   logic [STEPS_W-1:0]   ipf_ff;
   logic [7:0]           hi_ff, mid_ff, byte_ff;
   logic [PIXEL_W-1:0]   pix_ff;
   logic                 in_range_ff;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff;
   rgb_type              rsp_rgb_ff;
   logic [PTR_W-1:0]     rsp_pc_ff;

   logic                 req_ready;
   logic                 req_accept;
   logic                 in_range;
   logic [PTR_W-1:0]     ptr24;
   logic [ADDR_BITS-1:0] target;
   logic [PTR_W-1:0]     pix_sum;
   logic [ADDR_BITS-1:0] pix_at;
   logic [STEPS_W-1:0]   frame_steps;
   logic [3:0]           pc_offset;
   logic [IDX_BITS-1:0]  pc_plus;
   rgb_type              pix_rgb;
   logic                 rsp_load;

   assign req_ready        = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = req_ready;
   assign req_accept       = req_chan.valid && req_ready;
   assign in_range         = req_chan.address < ADDRESS_W'(MEM_SIZE);

   assign ptr24       = {hi_ff, mid_ff, rdata_ff};
   assign target      = ptr24[ADDR_BITS-1:0];
   assign pix_sum     = {rdata_ff, 16'h0000} + PTR_W'(pix_ff);
   assign pix_at      = pix_sum[ADDR_BITS-1:0];
   assign frame_steps = (ipf_ff > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS) : ipf_ff;
   assign pc_plus     = {1'b0, pc_ff} + IDX_BITS'(pc_offset);
   assign pix_rgb     = cube_rgb(rdata_ff);

   assign rsp_load = (state_ff == S_RDATA) || (state_ff == S_PIXD)
                  || (req_accept && req_chan.action == ACT_WRITE)
                  || (state_ff == S_LD3 && frame_steps == '0)
                  || (state_ff == S_JMP && steps_ff == STEPS_W'(1));

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.red       = rsp_rgb_ff.red;
   assign rsp_chan.green     = rsp_rgb_ff.green;
   assign rsp_chan.blue      = rsp_rgb_ff.blue;
   assign rsp_chan.final_pc  = rsp_pc_ff;

   // pointer byte offset from pc in each instruction phase
   always_comb begin
      case (state_ff)
         S_A1:    pc_offset = 4'd1;
         S_A2:    pc_offset = 4'd2;
         S_B0:    pc_offset = 4'd3;
         S_B1:    pc_offset = 4'd4;
         S_B2:    pc_offset = 4'd5;
         S_C0:    pc_offset = 4'd6;
         S_C1:    pc_offset = 4'd7;
         S_C2:    pc_offset = 4'd8;
         default: pc_offset = 4'd0;
      endcase
   end

   // memory port: one access per cycle, read data returns in the next cycle through rdata_ff
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = byte_ff;
      mem_addr  = pc_plus;
      case (state_ff)
         S_IDLE: begin
            mem_wdata = req_chan.write_data;
            mem_we    = req_accept && (req_chan.action == ACT_WRITE) && in_range;
            if (req_chan.action == ACT_PIXEL) begin
               mem_addr = IDX_BITS'(PAGE_ADR);
            end else begin
               mem_addr = req_chan.address[IDX_BITS-1:0];
            end
         end
         S_PIX5: mem_addr = {1'b0, pix_at};
         S_LD0:  mem_addr = IDX_BITS'(START_PC_ADR);
         S_LD1:  mem_addr = IDX_BITS'(START_PC_ADR + 1);
         S_LD2:  mem_addr = IDX_BITS'(START_PC_ADR + 2);
         S_LD3, S_JMP, S_AP: mem_addr = {1'b0, target};
         S_WR: begin
            mem_addr = {1'b0, target};
            mem_we   = 1'b1;
         end
         default: mem_addr = pc_plus;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         memory_ff[mem_addr] <= mem_wdata;
      end
      rdata_ff <= memory_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipf_ff <= STEPS_W'(MAX_STEPS);
      end else if (csr_we) begin
         ipf_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  case (req_chan.action)
                     ACT_WRITE: begin
                        rsp_data_ff <= '0;
                        rsp_rgb_ff  <= '0;
                        rsp_pc_ff   <= PTR_W'(pc_ff);
                     end
                     ACT_READ: begin
                        in_range_ff <= in_range;
                        state_ff    <= S_RDATA;
                     end
                     ACT_RUN: state_ff <= S_LD0;
                     ACT_PIXEL: begin
                        pix_ff   <= req_chan.pixel_index;
                        state_ff <= S_PIX5;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_RDATA: begin
               rsp_data_ff <= in_range_ff ? rdata_ff : 8'h00;
               rsp_rgb_ff  <= '0;
               rsp_pc_ff   <= PTR_W'(pc_ff);
               state_ff    <= S_IDLE;
            end
            S_PIX5: state_ff <= S_PIXD;
            S_PIXD: begin
               rsp_data_ff <= rdata_ff;
               rsp_rgb_ff  <= pix_rgb;
               rsp_pc_ff   <= PTR_W'(pc_ff);
               state_ff    <= S_IDLE;
            end
            S_LD0: state_ff <= S_LD1;
            S_LD1: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_LD2;
            end
            S_LD2: begin
               mid_ff   <= rdata_ff;
               state_ff <= S_LD3;
            end
            S_LD3: begin
               pc_ff    <= target;
               steps_ff <= frame_steps;
               if (frame_steps == '0) begin
                  rsp_data_ff <= '0;
                  rsp_rgb_ff  <= '0;
                  rsp_pc_ff   <= PTR_W'(target);
                  state_ff    <= S_IDLE;
               end else begin
                  state_ff <= S_A1;
               end
            end
            S_A1: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_A2;
            end
            S_A2: begin
               mid_ff   <= rdata_ff;
               state_ff <= S_AP;
            end
            S_AP: state_ff <= S_B0;
            S_B0: begin
               byte_ff  <= rdata_ff;
               state_ff <= S_B1;
            end
            S_B1: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_B2;
            end
            S_B2: begin
               mid_ff   <= rdata_ff;
               state_ff <= S_WR;
            end
            // the copy lands before the jump bytes are read, so it may change C
            S_WR: state_ff <= S_C0;
            S_C0: state_ff <= S_C1;
            S_C1: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_C2;
            end
            S_C2: begin
               mid_ff   <= rdata_ff;
               state_ff <= S_JMP;
            end
            S_JMP: begin
               pc_ff    <= target;
               steps_ff <= steps_ff - STEPS_W'(1);
               if (steps_ff == STEPS_W'(1)) begin
                  rsp_data_ff <= '0;
                  rsp_rgb_ff  <= '0;
                  rsp_pc_ff   <= PTR_W'(target);
                  state_ff    <= S_IDLE;
               end else begin
                  state_ff <= S_A1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response loaded over a held beat");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_WR) || (req_accept && req_chan.action == ACT_WRITE))
      else $error("memory write outside a write beat or copy phase");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= STEPS_W'(MAX_STEPS))
      else $error("step counter above frame limit");

   a_steps_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A1 || state_ff == S_WR || state_ff == S_JMP) |-> (steps_ff != '0))
      else $error("instruction phase with no steps left");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JMP && steps_ff == STEPS_W'(1)) |=>
         (rsp_valid_ff && state_ff == S_IDLE && rsp_pc_ff == PTR_W'(pc_ff)))
      else $error("frame end without matching response");

endmodule
